[hw/rtl/wsg_pkg.sv]
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, codes and helpers for the waypoint steering guidance block.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // event codes on the input channel
  localparam logic [1:0] MODE_GPS   = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_RELAY = 2'd3;

  // result kinds on the output channel
  localparam logic [1:0] KIND_STEER    = 2'd0;
  localparam logic [1:0] KIND_REACHED  = 2'd1;
  localparam logic [1:0] KIND_RELAY    = 2'd2;
  localparam logic [1:0] KIND_REJECTED = 2'd3;

  // command words
  localparam logic [6:0] CMD_NONE   = 7'd0;
  localparam logic [6:0] CMD_CENTER = 7'd50;
  localparam logic [6:0] CMD_RIGHT  = 7'd55;
  localparam logic [6:0] CMD_LEFT   = 7'd45;
  localparam logic [6:0] CMD_RELAY  = 7'd120;

  localparam logic [15:0] REACH_RADIUS_RESET = 16'd512;

  // cosine thresholds as integer ratios against the root
  localparam int unsigned FAR_SCALE   = 10;
  localparam int unsigned POS_SCALE   = 50;
  localparam int unsigned NEG_SCALE   = 5000;
  localparam int unsigned NEG_STEP    = 100;

  // request into the steering unit
  typedef struct packed {
    logic        start;
    logic [15:0] reach_radius;
  } wsg_steer_req_t;

  // answer from the steering unit
  typedef struct packed {
    logic       done;
    logic       reached;
    logic [6:0] command;
  } wsg_steer_rsp_t;

  // saturate a 33-bit signed difference to 32 bits
  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/wsg_if.sv]
// ----------------------------------------------------------------------------
// wsg channel interfaces
// Valid/ready channels for input events and result transactions.
// ----------------------------------------------------------------------------
interface wsg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, output mode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input mode, input coord_x, input coord_y, output ready);
endinterface

interface wsg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] command;
  logic       relay_on;
  logic [6:0] waypoints_left;

  modport source (output valid, output kind, output command, output relay_on,
                  output waypoints_left, input ready);
  modport sink   (input valid, input kind, input command, input relay_on,
                  input waypoints_left, output ready);
endinterface

[hw/rtl/wsg_ram.sv]
// ----------------------------------------------------------------------------
// wsg_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wsg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/wsg_isqrt.sv]
// ----------------------------------------------------------------------------
// wsg_isqrt
// Floor square root of a 128-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module wsg_isqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] operand,
  output logic         done,
  output logic [63:0]  root
);

  logic [127:0] src;
  logic [65:0]  rem;
  logic [6:0]   cnt;
  logic         busy;
  logic [66:0]  rem_sh;
  logic [66:0]  trial;
  logic         fits;

  // one digit of the restoring square root
  assign rem_sh = {rem[64:0], src[127:126]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      src  <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[125:0], 2'b00};
      rem  <= fits ? 66'(rem_sh - trial) : rem_sh[65:0];
      root <= {root[62:0], fits};
    end
  end

endmodule

[hw/rtl/wsg_steer.sv]
// ----------------------------------------------------------------------------
// wsg_steer
// Tick sequencer: squared lengths, dot product, reach test, root and command.
// ----------------------------------------------------------------------------
module wsg_steer (
  input  logic                    clk,
  input  logic                    rst,
  input  wsg_pkg::wsg_steer_req_t req,
  input  logic signed [32:0]      vx,
  input  logic signed [32:0]      vy,
  input  logic signed [32:0]      nx,
  input  logic signed [32:0]      ny,
  output wsg_pkg::wsg_steer_rsp_t rsp
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0]         state;
  logic [3:0]         step;
  logic signed [32:0] ax, ay, bx, by;
  logic [31:0]        rr2;
  logic signed [65:0] prod;
  logic [63:0]        lv, ln, dot, d;
  logic [127:0]       wide;
  logic               sq_start;
  logic               sq_done;
  logic [63:0]        sq_root;
  logic [79:0]        mk, dm, dstep;
  logic               neg;
  logic [2:0]         ncmp;
  logic [6:0]         cmd;
  logic               done;
  logic               reached;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mult;
  logic [63:0]        mag;
  logic [67:0]        mag10;
  logic               hit;
  logic               last_cmp;
  logic [6:0]         cmd_step;

  // shared multiplier operand selection
  always_comb begin
    case (step)
      4'd0:    begin ma = ax; mb = ax; end
      4'd1:    begin ma = ay; mb = ay; end
      4'd2:    begin ma = bx; mb = bx; end
      4'd3:    begin ma = by; mb = by; end
      4'd4:    begin ma = ax; mb = bx; end
      4'd5:    begin ma = ay; mb = by; end
      4'd6:    begin ma = $signed({1'b0, lv[31:0]});  mb = $signed({1'b0, ln[31:0]});  end
      4'd7:    begin ma = $signed({1'b0, lv[31:0]});  mb = $signed({1'b0, ln[63:32]}); end
      4'd8:    begin ma = $signed({1'b0, lv[63:32]}); mb = $signed({1'b0, ln[31:0]});  end
      default: begin ma = $signed({1'b0, lv[63:32]}); mb = $signed({1'b0, ln[63:32]}); end
    endcase
  end

  assign mult = ma * mb;

  // projection magnitude and compare terms
  assign mag      = neg ? 64'(-dot) : dot;
  assign mag10    = 68'(mag) * 68'(wsg_pkg::FAR_SCALE);
  assign hit      = mk >= dm;
  assign last_cmp = neg ? (ncmp == 3'd4) : (ncmp == 3'd3);
  assign cmd_step = hit ? (neg ? cmd - 7'd1 : cmd + 7'd1) : cmd;

  wsg_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (wide),
    .done    (sq_done),
    .root    (sq_root)
  );

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      sq_start <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      sq_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_MUL;
            step  <= '0;
          end
        end
        ST_MUL: begin
          step <= step + 4'd1;
          if (step == 4'd10) begin
            if (lv < 64'(rr2)) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              sq_start <= 1'b1;
              state    <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (d == '0 || mag10 >= 68'(d)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (last_cmp) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.start) begin
      ax  <= vx;
      ay  <= vy;
      bx  <= nx;
      by  <= ny;
      rr2 <= 32'(req.reach_radius) * 32'(req.reach_radius);
    end
    if (state == ST_MUL) begin
      prod <= mult;
      // accumulate the product of the previous step
      case (step)
        4'd1:    lv   <= prod[63:0];
        4'd2:    lv   <= lv + prod[63:0];
        4'd3:    ln   <= prod[63:0];
        4'd4:    ln   <= ln + prod[63:0];
        4'd5:    dot  <= prod[63:0];
        4'd6:    dot  <= dot + prod[63:0];
        4'd7:    wide <= 128'(prod[63:0]);
        4'd8:    wide <= wide + (128'(prod[63:0]) << 32);
        4'd9:    wide <= wide + (128'(prod[63:0]) << 32);
        4'd10:   wide <= wide + (128'(prod[63:0]) << 64);
        default: ;
      endcase
      if (step == 4'd10) begin
        reached <= lv < 64'(rr2);
        cmd     <= wsg_pkg::CMD_NONE;
      end
    end
    if (state == ST_SQRT && sq_done) begin
      d   <= sq_root;
      neg <= dot[63];
    end
    if (state == ST_PREP) begin
      // zero length gives center, large cosine gives full deflection
      if (d == '0) begin
        cmd <= wsg_pkg::CMD_CENTER;
      end else if (mag10 >= 68'(d)) begin
        cmd <= neg ? wsg_pkg::CMD_LEFT : wsg_pkg::CMD_RIGHT;
      end else begin
        cmd   <= wsg_pkg::CMD_CENTER;
        mk    <= neg ? 80'(mag) * 80'(wsg_pkg::NEG_SCALE) : 80'(mag) * 80'(wsg_pkg::POS_SCALE);
        dm    <= 80'(d);
        dstep <= neg ? 80'(d) * 80'(wsg_pkg::NEG_STEP) : 80'(d);
        ncmp  <= '0;
      end
    end
    if (state == ST_CMP) begin
      cmd  <= cmd_step;
      dm   <= dm + dstep;
      ncmp <= ncmp + 3'd1;
    end
  end

  assign rsp.done    = done;
  assign rsp.reached = reached;
  assign rsp.command = cmd;

endmodule

[hw/rtl/waypoint_steering_guidance.sv]
// ----------------------------------------------------------------------------
// waypoint_steering_guidance
// Event-driven waypoint follower producing steering and relay commands.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one event per transaction: gps fix, add
// waypoint, control tick or relay toggle. Output channel out_ch carries at
// most one result transaction per event. cfg_we/cfg_wdata write reach_radius.
// One event is processed at a time; in_ch.ready is high while idle.
// Gps fixes, accepted adds and ticks without a result leave the block idle.
// Relay toggles and rejected adds go to ST_EMIT, which loads the result
// register once it is free. A tick that steers passes, on its way from
// acceptance to the result register, through the waypoint read, the multiply
// sequence, root start, square root (one bit per cycle in wsg_isqrt), root
// capture, threshold setup and compares, handoff and result. A reached
// waypoint skips the root.
// Waypoints live in a RAM of WAYPOINT_DEPTH entries used as a circular queue.
// Reset clears origin, positions, queue pointers, relay and sets reach_radius
// to 512; the queue contents are not cleared.
// The output register holds a result while out_ch is stalled; a new event is
// still accepted, and only the next result waits for the register to free.
// ----------------------------------------------------------------------------
module waypoint_steering_guidance #(
  parameter int WAYPOINT_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  wsg_in_if.sink      in_ch,
  wsg_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
  localparam int CW = $clog2(WAYPOINT_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_TICK = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]        state;
  logic [15:0]       reach_radius;
  logic              origin_valid;
  logic [31:0]       origin_x, origin_y;
  logic [31:0]       last_x, last_y, prev_x, prev_y;
  logic [1:0]        positions_seen;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic              relay_state;
  logic [1:0]        pend_kind;
  logic [6:0]        pend_cmd;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [6:0]        out_cmd;
  logic              out_relay;
  logic [6:0]        out_left;

  logic              accept;
  logic              full;
  logic [CW:0]       slot_sum;
  logic [AW-1:0]     slot;
  logic [31:0]       base_x, base_y;
  logic [31:0]       rel_x, rel_y;
  logic              ram_we;
  logic [63:0]       ram_rdata;
  logic [31:0]       hx, hy, tvx, tvy;
  logic              emit_free;

  wsg_pkg::wsg_steer_req_t req;
  wsg_pkg::wsg_steer_rsp_t rsp;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign full      = (count == CW'(WAYPOINT_DEPTH));
  assign emit_free = !out_valid || out_ch.ready;

  // queue tail slot, wrapped at the depth
  assign slot_sum = (CW+1)'(head) + (CW+1)'(count);
  assign slot     = (slot_sum >= (CW+1)'(WAYPOINT_DEPTH))
                  ? AW'(slot_sum - (CW+1)'(WAYPOINT_DEPTH)) : AW'(slot_sum);

  // origin-relative gps position
  assign base_x = origin_valid ? origin_x : in_ch.coord_x;
  assign base_y = origin_valid ? origin_y : in_ch.coord_y;
  assign rel_x  = wsg_pkg::sat32($signed({in_ch.coord_x[31], in_ch.coord_x})
                               - $signed({base_x[31], base_x}));
  assign rel_y  = wsg_pkg::sat32($signed({in_ch.coord_y[31], in_ch.coord_y})
                               - $signed({base_y[31], base_y}));

  assign ram_we = accept && (in_ch.mode == wsg_pkg::MODE_ADD) && !full;

  wsg_ram #(
    .WIDTH (64),
    .DEPTH (WAYPOINT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({in_ch.coord_x, in_ch.coord_y}),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // heading and vector to the head waypoint
  assign hx  = wsg_pkg::sat32($signed({last_x[31], last_x}) - $signed({prev_x[31], prev_x}));
  assign hy  = wsg_pkg::sat32($signed({last_y[31], last_y}) - $signed({prev_y[31], prev_y}));
  assign tvx = wsg_pkg::sat32($signed({ram_rdata[63], ram_rdata[63:32]})
                            - $signed({last_x[31], last_x}));
  assign tvy = wsg_pkg::sat32($signed({ram_rdata[31], ram_rdata[31:0]})
                            - $signed({last_y[31], last_y}));

  assign req.start        = (state == ST_READ);
  assign req.reach_radius = reach_radius;

  wsg_steer u_steer (
    .clk (clk),
    .rst (rst),
    .req (req),
    .vx  ($signed({tvx[31], tvx})),
    .vy  ($signed({tvy[31], tvy})),
    .nx  ($signed({hy[31], hy})),
    .ny  (-$signed({hx[31], hx})),
    .rsp (rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reach_radius <= wsg_pkg::REACH_RADIUS_RESET;
    end else if (cfg_we) begin
      reach_radius <= cfg_wdata;
    end
  end

  // event sequencer and guidance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      origin_valid   <= 1'b0;
      origin_x       <= '0;
      origin_y       <= '0;
      last_x         <= '0;
      last_y         <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      positions_seen <= '0;
      head           <= '0;
      count          <= '0;
      relay_state    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_ch.mode)
              wsg_pkg::MODE_GPS: begin
                if (!origin_valid) begin
                  origin_x     <= in_ch.coord_x;
                  origin_y     <= in_ch.coord_y;
                  origin_valid <= 1'b1;
                end
                prev_x <= last_x;
                prev_y <= last_y;
                last_x <= rel_x;
                last_y <= rel_y;
                if (positions_seen != 2'd2) begin
                  positions_seen <= positions_seen + 2'd1;
                end
              end
              wsg_pkg::MODE_ADD: begin
                if (full) begin
                  pend_kind <= wsg_pkg::KIND_REJECTED;
                  pend_cmd  <= wsg_pkg::CMD_NONE;
                  state     <= ST_EMIT;
                end else begin
                  count <= count + CW'(1);
                end
              end
              wsg_pkg::MODE_TICK: begin
                if (positions_seen == 2'd2 && count != '0) begin
                  state <= ST_READ;
                end
              end
              default: begin
                relay_state <= !relay_state;
                pend_kind   <= wsg_pkg::KIND_RELAY;
                pend_cmd    <= wsg_pkg::CMD_RELAY;
                state       <= ST_EMIT;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_TICK;
        end
        ST_TICK: begin
          if (rsp.done) begin
            if (rsp.reached) begin
              head      <= (head == AW'(WAYPOINT_DEPTH - 1)) ? '0 : head + AW'(1);
              count     <= count - CW'(1);
              pend_kind <= wsg_pkg::KIND_REACHED;
              pend_cmd  <= wsg_pkg::CMD_NONE;
            end else begin
              pend_kind <= wsg_pkg::KIND_STEER;
              pend_cmd  <= rsp.command;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && emit_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_free) begin
      out_kind  <= pend_kind;
      out_cmd   <= pend_cmd;
      out_relay <= relay_state;
      out_left  <= 7'(count);
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.kind           = out_kind;
  assign out_ch.command        = out_cmd;
  assign out_ch.relay_on       = out_relay;
  assign out_ch.waypoints_left = out_left;

  // queue occupancy stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(WAYPOINT_DEPTH))
    else $error("waypoint count above depth");

  // the steering unit answers only while a tick waits for it
  a_rsp_in_tick: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == ST_TICK)
    else $error("steering answer outside a tick");

  // a reached waypoint always leaves one fewer queued
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && rsp.done && rsp.reached) |=> count == $past(count) - CW'(1))
    else $error("reached waypoint not popped");

endmodule

[bench/waypoint_steering_guidance_tb.sv]
// ----------------------------------------------------------------------------
// waypoint_steering_guidance_tb
// Self-checking bench for the waypoint follower: directed tests for queue
// overflow, coordinate saturation, zero heading and relay events, followed by
// random event traces steered toward queued waypoints. A local predictor
// computes each result transaction, which is checked field by field.
// ----------------------------------------------------------------------------
module waypoint_steering_guidance_tb;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] command;
    logic       relay_on;
    logic [6:0] waypoints_left;
  } guidance_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  wsg_in_if  in_ch ();
  wsg_out_if out_ch ();

  waypoint_steering_guidance #(.WAYPOINT_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted guidance state
  logic               gd_origin_ok;
  logic signed [63:0] gd_origin_x, gd_origin_y;
  logic signed [63:0] gd_last_x, gd_last_y, gd_prev_x, gd_prev_y;
  int                 gd_fixes;
  logic signed [63:0] gd_wp_x [DEPTH];
  logic signed [63:0] gd_wp_y [DEPTH];
  int                 gd_head, gd_count;
  logic               gd_relay;
  logic [15:0]        gd_radius;

  guidance_result_t expected_results [$];
  int               mismatches;
  bit               long_stalls;
  int               out_gap;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // steering command from waypoint vector v and heading normal n
  function automatic logic [6:0] steering_command(input logic signed [63:0] vx, vy, nx, ny);
    logic [63:0]  lv, ln, root, cand, dot, mg;
    logic [127:0] prod, mg_w, root_w;
    logic         neg;
    logic [6:0]   cmd;
    lv = magnitude(vx) * magnitude(vx) + magnitude(vy) * magnitude(vy);
    ln = magnitude(nx) * magnitude(nx) + magnitude(ny) * magnitude(ny);
    prod = {64'd0, lv} * {64'd0, ln};
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= prod) root = cand;
    end
    dot = vx * nx + vy * ny;
    neg = dot[63];
    mg = neg ? -dot : dot;
    if (root == 0) return wsg_pkg::CMD_CENTER;
    mg_w = {64'd0, mg};
    root_w = {64'd0, root};
    // from a cosine of one tenth upward the command saturates
    if (mg_w * 10 >= root_w) return neg ? wsg_pkg::CMD_LEFT : wsg_pkg::CMD_RIGHT;
    cmd = wsg_pkg::CMD_CENTER;
    if (!neg) begin
      for (int j = 1; j <= 4; j++)
        if (mg_w * 50 >= root_w * j) cmd++;
    end else begin
      for (int j = 0; j <= 4; j++)
        if (mg_w * 5000 >= root_w * (100 * j + 1)) cmd--;
    end
    return cmd;
  endfunction

  function automatic guidance_result_t make_result(input logic [1:0] kind,
                                                   input logic [6:0] cmd);
    guidance_result_t r;
    r.kind = kind;
    r.command = cmd;
    r.relay_on = gd_relay;
    r.waypoints_left = gd_count[6:0];
    return r;
  endfunction

  // advance predicted state by one accepted event
  task automatic predict_event(input logic [1:0] mode, input logic signed [31:0] cx,
                               input logic signed [31:0] cy);
    logic signed [63:0] x, y, hx, hy, vx, vy;
    logic [63:0]        dist2;
    x = cx;
    y = cy;
    case (mode)
      wsg_pkg::MODE_GPS: begin
        if (!gd_origin_ok) begin
          gd_origin_x = x;
          gd_origin_y = y;
          gd_origin_ok = 1'b1;
        end
        gd_prev_x = gd_last_x;
        gd_prev_y = gd_last_y;
        gd_last_x = clamp32(x - gd_origin_x);
        gd_last_y = clamp32(y - gd_origin_y);
        if (gd_fixes < 2) gd_fixes++;
      end
      wsg_pkg::MODE_ADD: begin
        if (gd_count >= DEPTH) begin
          expected_results.push_back(make_result(wsg_pkg::KIND_REJECTED, wsg_pkg::CMD_NONE));
        end else begin
          gd_wp_x[(gd_head + gd_count) % DEPTH] = x;
          gd_wp_y[(gd_head + gd_count) % DEPTH] = y;
          gd_count++;
        end
      end
      wsg_pkg::MODE_TICK: begin
        if (gd_fixes >= 2 && gd_count != 0) begin
          hx = clamp32(gd_last_x - gd_prev_x);
          hy = clamp32(gd_last_y - gd_prev_y);
          vx = clamp32(gd_wp_x[gd_head] - gd_last_x);
          vy = clamp32(gd_wp_y[gd_head] - gd_last_y);
          dist2 = magnitude(vx) * magnitude(vx) + magnitude(vy) * magnitude(vy);
          if (dist2 < 64'(gd_radius) * 64'(gd_radius)) begin
            gd_head = (gd_head + 1) % DEPTH;
            gd_count--;
            expected_results.push_back(make_result(wsg_pkg::KIND_REACHED, wsg_pkg::CMD_NONE));
          end else begin
            expected_results.push_back(make_result(wsg_pkg::KIND_STEER,
                                                   steering_command(vx, vy, hy, -hx)));
          end
        end
      end
      default: begin
        gd_relay = ~gd_relay;
        expected_results.push_back(make_result(wsg_pkg::KIND_RELAY, wsg_pkg::CMD_RELAY));
      end
    endcase
  endtask

  // input transaction monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      predict_event(in_ch.mode, in_ch.coord_x, in_ch.coord_y);
  end

  // result transaction checker
  always @(posedge clk) begin
    guidance_result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.kind;
      got.command = out_ch.command;
      got.relay_on = out_ch.relay_on;
      got.waypoints_left = out_ch.waypoints_left;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d command %0d relay %0d left %0d",
                   got.kind, got.command, got.relay_on, got.waypoints_left);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected kind %0d command %0d relay %0d left %0d,",
                      " got kind %0d command %0d relay %0d left %0d"},
                     want.kind, want.command, want.relay_on, want.waypoints_left,
                     got.kind, got.command, got.relay_on, got.waypoints_left);
        end
      end
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result-side stalls
  always @(posedge clk) begin
    if (rst || !long_stalls) begin
      out_gap = 0;
      out_ch.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_gap = gap_length();
      out_ch.ready <= (out_gap == 0);
      if (out_gap > 0) out_gap = out_gap - 1;
    end
  end

  // send one event and wait for its transaction, then idle a while
  task automatic send_event(input logic [1:0] mode, input logic [31:0] cx,
                            input logic [31:0] cy);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.coord_x <= cx;
    in_ch.coord_y <= cy;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    g = long_stalls ? gap_length() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // write reach radius once the block has drained
  task automatic set_reach_radius(input logic [15:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (120) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    gd_radius = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 32'($signed($urandom_range(0, 40000)) - 20000);
    if (r < 90) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // fill the queue, overflow it, then drain it with a wide reach radius
  task automatic test_queue_full();
    set_reach_radius(16'hffff);
    send_event(wsg_pkg::MODE_GPS, 32'h0001_0000, 32'hfff0_0000);
    send_event(wsg_pkg::MODE_GPS, 32'h0001_0100, 32'hfff0_0200);
    for (int i = 0; i < DEPTH; i++)
      send_event(wsg_pkg::MODE_ADD, 32'($signed(i * 8) + 256), 32'h200);
    send_event(wsg_pkg::MODE_ADD, 32'h1234, 32'h5678);
    send_event(wsg_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < DEPTH; i++)
      send_event(wsg_pkg::MODE_TICK, $urandom(), $urandom());
    send_event(wsg_pkg::MODE_TICK, 32'h0, 32'h0);
  endtask

  // saturation, zero heading, relay and extreme waypoints
  task automatic test_directed_cases();
    set_reach_radius(wsg_pkg::REACH_RADIUS_RESET);
    send_event(wsg_pkg::MODE_RELAY, 32'h7fff_ffff, 32'h8000_0000);
    send_event(wsg_pkg::MODE_RELAY, 32'h0, 32'hffff_ffff);
    send_event(wsg_pkg::MODE_ADD, 32'h0010_0000, 32'h0);
    // zero heading steers straight
    send_event(wsg_pkg::MODE_GPS, 32'h0001_0000, 32'hfff0_0000);
    send_event(wsg_pkg::MODE_GPS, 32'h0001_0000, 32'hfff0_0000);
    send_event(wsg_pkg::MODE_TICK, 32'h0, 32'h0);
    // small heading along x, waypoint ahead, left and right
    send_event(wsg_pkg::MODE_GPS, 32'h0001_0100, 32'hfff0_0000);
    send_event(wsg_pkg::MODE_TICK, 32'h0, 32'h0);
    send_event(wsg_pkg::MODE_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
    send_event(wsg_pkg::MODE_ADD, 32'h8000_0000, 32'h8000_0000);
    send_event(wsg_pkg::MODE_ADD, 32'h0000_0100, 32'h0000_0000);
    send_event(wsg_pkg::MODE_GPS, 32'h7fff_ffff, 32'h8000_0000);
    send_event(wsg_pkg::MODE_TICK, 32'h0, 32'h0);
    send_event(wsg_pkg::MODE_GPS, 32'h8000_0000, 32'h7fff_ffff);
    send_event(wsg_pkg::MODE_TICK, 32'h0, 32'h0);
    send_event(wsg_pkg::MODE_RELAY, 32'h0, 32'h0);
    send_event(wsg_pkg::MODE_TICK, 32'h0, 32'h0);
  endtask

  // random traces that mostly drive toward the head waypoint
  task automatic test_random_traces(input int items);
    int                 r;
    logic signed [63:0] px, py, spread;
    for (int n = 0; n < items; n++) begin
      if (n % 130 == 129) begin
        case ($urandom_range(0, 3))
          0: set_reach_radius(16'h0);
          1: set_reach_radius(16'hffff);
          2: set_reach_radius(wsg_pkg::REACH_RADIUS_RESET);
          default: set_reach_radius(16'($urandom()));
        endcase
      end
      long_stalls = (n / 60) % 3 != 2;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if (gd_origin_ok && gd_count > 0 && $urandom_range(0, 99) < 70) begin
          spread = 64'(gd_radius) * 2 + 600;
          px = gd_origin_x + gd_wp_x[gd_head] + $signed($urandom_range(0, 2 * spread)) - spread;
          py = gd_origin_y + gd_wp_y[gd_head] + $signed($urandom_range(0, 2 * spread)) - spread;
          send_event(wsg_pkg::MODE_GPS, px[31:0], py[31:0]);
        end else begin
          send_event(wsg_pkg::MODE_GPS, random_coord(), random_coord());
        end
      end else if (r < 52) begin
        send_event(wsg_pkg::MODE_ADD, random_coord(), random_coord());
      end else if (r < 92) begin
        send_event(wsg_pkg::MODE_TICK, $urandom(), $urandom());
      end else begin
        send_event(wsg_pkg::MODE_RELAY, $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = wsg_pkg::MODE_GPS;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    mismatches = 0;
    long_stalls = 1'b1;
    gd_origin_ok = 1'b0;
    gd_origin_x = 0;
    gd_origin_y = 0;
    gd_last_x = 0;
    gd_last_y = 0;
    gd_prev_x = 0;
    gd_prev_y = 0;
    gd_fixes = 0;
    gd_head = 0;
    gd_count = 0;
    gd_relay = 1'b0;
    gd_radius = wsg_pkg::REACH_RADIUS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_queue_full();
    test_directed_cases();
    test_random_traces(520);

    in_ch.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/wsg_pkg.sv
hw/rtl/wsg_if.sv
hw/rtl/wsg_ram.sv
hw/rtl/wsg_isqrt.sv
hw/rtl/wsg_steer.sv
hw/rtl/waypoint_steering_guidance.sv
bench/waypoint_steering_guidance_tb.sv
